/* hw/rtl/safp_pkg.sv */
package safp_pkg;

   localparam int NUM_SERVOS_DEF = 4;

   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_BANG = 8'h21;
   localparam logic [7:0] CH_P    = 8'h50;
   localparam logic [7:0] CH_ZERO = 8'h30;

   localparam logic [3:0] FRAME_LEN  = 4'd10;
   localparam int         FRAME_CHARS = 8;

   localparam logic [15:0] ANGLE_LOW  = 16'd500;
   localparam logic [15:0] ANGLE_HIGH = 16'd2500;

   typedef enum logic {
      OP_BYTE  = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef struct packed {
      logic [15:0] angle;
      logic        fresh;
   } entry_type;

endpackage

/* hw/rtl/safp_ram.sv */
module safp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/servo_angle_frame_parser.sv */
// Servo reply parser: takes received UART characters of "#iiiPaaaa!" frames and queries, one
// beat per cycle, and returns exactly one result beat for each. A frame whose id is below
// NUM_SERVOS and that has P before the angle stores it in the table and marks it fresh; a query
// returns and clears the fresh mark and gives the angle when it lies in 501..2499. The angle
// table lives in a RAM with a registered read: every beat reads its entry at acceptance, and a
// query writes the cleared mark back when it moves on to the result register, with that write
// forwarded to a read of the same entry at the same edge. An accepted beat waits in stage 1
// and moves on to the result register once that register is free, where its result beat is
// offered; a new beat is taken every cycle while the result side keeps draining.
module servo_angle_frame_parser
   import safp_pkg::*;
#(
   parameter int NUM_SERVOS = NUM_SERVOS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] rx_byte, [15:8] servo_id
   input  logic        req_tuser,   // [0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [0] frame_stored, [1] fresh, [2] angle_in_range,
                                    // [14:3] angle_out, [15] zero
);

   localparam int ADDR_W  = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
   localparam int ENTRY_W = $bits(entry_type);

   // input decode
   logic              req_fire;
   op_type            req_op;
   logic [7:0]        rx_byte;
   logic [7:0]        servo_id;

   // frame capture
   logic [3:0]        cap_pos_ff, cap_pos_in;
   logic [7:0]        frame_chars_ff [FRAME_CHARS];
   logic [3:0]        pos_step;
   logic              char_we;
   logic [2:0]        char_idx;
   logic              frame_done;
   logic [7:0]        dig_id [3];
   logic [15:0]       dig_ang [4];
   logic [7:0]        dec_id;
   logic [15:0]       dec_angle;
   logic              id_ok;
   logic              query_ok;

   // stage 1
   logic              s1_valid_ff;
   logic              s1_query_ff;
   logic              s1_store_ff;
   logic              s1_hit_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic [15:0]       s1_angle_ff;
   logic              s1_fwd_ff;
   entry_type         s1_fwd_data_ff;
   logic              s1_rvalid_ff;
   logic [ADDR_W-1:0] s1_addr_in;
   logic              s1_go;
   logic              out_free;

   // table
   logic [NUM_SERVOS-1:0] valid_ff;
   logic              ram_we;
   entry_type         ram_wdata;
   logic [ENTRY_W-1:0] ram_q;
   entry_type         rd_entry;
   logic              q_fresh;
   logic              in_range;
   logic [11:0]       angle_out;

   // result
   logic              rsp_valid_ff;
   logic [15:0]       rsp_data_ff;
   logic [15:0]       rsp_data_in;

   assign rx_byte  = req_tdata[7:0];
   assign servo_id = req_tdata[15:8];
   assign req_op   = op_type'(req_tuser);

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_go      = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_fire   = req_tvalid && req_tready;

   // ---------------- frame capture ----------------
   always_comb begin
      pos_step = cap_pos_ff;
      if (cap_pos_ff != 4'd0 && cap_pos_ff < FRAME_LEN) begin
         pos_step = cap_pos_ff + 4'd1;
      end
      char_we  = (cap_pos_ff != 4'd0) && (cap_pos_ff <= 4'(FRAME_CHARS));
      char_idx = 3'(cap_pos_ff - 4'd1);
   end

   assign frame_done = (rx_byte != CH_HASH) && (rx_byte == CH_BANG) && (pos_step == FRAME_LEN);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dig_id[i] = frame_chars_ff[i] - CH_ZERO;
      end
      for (int i = 0; i < 4; i++) begin
         dig_ang[i] = {8'd0, frame_chars_ff[i + 4]} - {8'd0, CH_ZERO};
      end
      dec_id    = 8'(dig_id[0] * 8'd100 + dig_id[1] * 8'd10 + dig_id[2]);
      dec_angle = 16'(dig_ang[0] * 16'd1000 + dig_ang[1] * 16'd100 +
                      dig_ang[2] * 16'd10 + dig_ang[3]);
   end

   assign id_ok    = ({1'b0, dec_id} < 9'(NUM_SERVOS)) && (frame_chars_ff[3] == CH_P);
   assign query_ok = {1'b0, servo_id} < 9'(NUM_SERVOS);

   always_comb begin
      cap_pos_in = cap_pos_ff;
      if (req_fire && req_op == OP_BYTE) begin
         if (rx_byte == CH_HASH) begin
            cap_pos_in = 4'd1;
         end else if (frame_done) begin
            cap_pos_in = 4'd0;
         end else begin
            cap_pos_in = pos_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_pos_ff <= 4'd0;
      end else begin
         cap_pos_ff <= cap_pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_op == OP_BYTE && rx_byte != CH_HASH && char_we) begin
         frame_chars_ff[char_idx] <= rx_byte;
      end
   end

   // ---------------- stage 1: table read-modify-write ----------------
   assign s1_addr_in = (req_op == OP_QUERY) ? servo_id[ADDR_W-1:0] : dec_id[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_query_ff    <= (req_op == OP_QUERY);
         s1_store_ff    <= (req_op == OP_BYTE) && frame_done && id_ok;
         s1_hit_ff      <= query_ok;
         s1_addr_ff     <= s1_addr_in;
         s1_angle_ff    <= dec_angle;
         // forward the write leaving stage 1 now; the RAM returns the old word
         s1_fwd_ff      <= ram_we && (s1_addr_ff == s1_addr_in);
         s1_fwd_data_ff <= ram_wdata;
         s1_rvalid_ff   <= valid_ff[s1_addr_in];
      end
   end

   always_comb begin
      if (s1_fwd_ff) begin
         rd_entry = s1_fwd_data_ff;
      end else if (s1_rvalid_ff) begin
         rd_entry = entry_type'(ram_q);
      end else begin
         rd_entry = '0;
      end
      q_fresh  = s1_query_ff && s1_hit_ff && rd_entry.fresh;
      in_range = q_fresh && (rd_entry.angle > ANGLE_LOW) && (rd_entry.angle < ANGLE_HIGH);
      angle_out = in_range ? rd_entry.angle[11:0] : 12'd0;
      ram_we   = s1_go && (s1_store_ff || q_fresh);
      if (s1_store_ff) begin
         ram_wdata.angle = s1_angle_ff;
         ram_wdata.fresh = 1'b1;
      end else begin
         ram_wdata.angle = rd_entry.angle;
         ram_wdata.fresh = 1'b0;
      end
   end

   safp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_SERVOS)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (s1_addr_ff),
      .wdata (ram_wdata),
      .re    (req_fire),
      .raddr (s1_addr_in),
      .rdata (ram_q)
   );

   // entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ram_we) begin
         valid_ff[s1_addr_ff] <= 1'b1;
      end
   end

   // ---------------- result register ----------------
   assign rsp_data_in = {1'b0, angle_out, in_range, q_fresh, s1_store_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------- assertions ----------------
   a_no_write_on_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |-> !ram_we)
      else $error("table written while stage 1 is stalled");

   a_store_xor_query: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[1]))
      else $error("result marks both frame stored and fresh");

   a_range_needs_fresh: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[2]) |-> rsp_tdata[1])
      else $error("in-range angle without fresh flag");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      cap_pos_ff <= FRAME_LEN)
      else $error("frame position beyond frame length");

   a_valid_after_write: assert property (@(posedge clock) disable iff (reset)
      ram_we |=> valid_ff[$past(s1_addr_ff)])
      else $error("written entry not marked valid");

endmodule

/* dv/servo_angle_frame_parser_checker.sv */
module servo_angle_frame_parser_checker
   import safp_pkg::*;
#(
   parameter int NUM_SERVOS = NUM_SERVOS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] rx_byte, [15:8] servo_id
   input  logic        req_tuser,   // [0] op
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // [0] frame_stored, [1] fresh, [2] angle_in_range,
                                    // [14:3] angle_out, [15] zero
   output int          mismatches,
   output int          pending
);

   localparam int ADDR_W = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;

   typedef struct packed {
      logic        stored;
      logic        fresh;
      logic        in_range;
      logic [11:0] angle;
   } reply_type;

   logic [7:0]  frame_buf [FRAME_CHARS];
   logic [3:0]  cap_pos;
   logic [15:0] angle_tab [NUM_SERVOS];
   logic        fresh_tab [NUM_SERVOS];
   reply_type   replies_due [$];
   int          fault_count;

   function automatic logic [31:0] digit_val(input logic [7:0] c);
      return {24'd0, c} - {24'd0, CH_ZERO};
   endfunction

   // Advance the parser and servo table by one beat and return the reply it owes.
   function automatic reply_type parse_beat(input op_type op, input logic [7:0] ch,
                                            input logic [7:0] sid);
      reply_type   r;
      logic [31:0] id_sum;
      logic [31:0] ang_sum;
      logic [15:0] ang;
      r = '0;
      if (op == OP_BYTE) begin
         if (ch == CH_HASH) begin
            cap_pos = 4'd1;
         end else begin
            if (cap_pos != 4'd0 && cap_pos < FRAME_LEN) begin
               if (cap_pos <= 4'd8) frame_buf[3'(cap_pos - 4'd1)] = ch;
               cap_pos = cap_pos + 4'd1;
            end
            if (ch == CH_BANG && cap_pos == FRAME_LEN) begin
               cap_pos = 4'd0;
               id_sum = digit_val(frame_buf[0]) * 100 + digit_val(frame_buf[1]) * 10 +
                        digit_val(frame_buf[2]);
               if (frame_buf[3] == CH_P && id_sum[7:0] < NUM_SERVOS) begin
                  ang_sum = digit_val(frame_buf[4]) * 1000 + digit_val(frame_buf[5]) * 100 +
                            digit_val(frame_buf[6]) * 10 + digit_val(frame_buf[7]);
                  angle_tab[id_sum[ADDR_W-1:0]] = ang_sum[15:0];
                  fresh_tab[id_sum[ADDR_W-1:0]] = 1'b1;
                  r.stored = 1'b1;
               end
            end
         end
      end else if (sid < NUM_SERVOS && fresh_tab[sid[ADDR_W-1:0]]) begin
         ang = angle_tab[sid[ADDR_W-1:0]];
         r.fresh = 1'b1;
         if (ang > ANGLE_LOW && ang < ANGLE_HIGH) begin
            r.in_range = 1'b1;
            r.angle = ang[11:0];
         end
         fresh_tab[sid[ADDR_W-1:0]] = 1'b0;
      end
      return r;
   endfunction

   always @(posedge clock) begin : watch
      reply_type got;
      reply_type want;
      if (reset) begin
         cap_pos = 4'd0;
         for (int i = 0; i < FRAME_CHARS; i++) frame_buf[i] = 8'd0;
         for (int i = 0; i < NUM_SERVOS; i++) begin
            angle_tab[i] = 16'd0;
            fresh_tab[i] = 1'b0;
         end
         replies_due.delete();
         fault_count = 0;
      end else begin
         // A reply beat can never belong to a request taken at the same edge: pop first.
         if (rsp_tvalid && rsp_tready) begin
            got.stored   = rsp_tdata[0];
            got.fresh    = rsp_tdata[1];
            got.in_range = rsp_tdata[2];
            got.angle    = rsp_tdata[14:3];
            if (replies_due.size() == 0) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("%0t: reply beat %h with nothing outstanding", $realtime, rsp_tdata);
            end else begin
               want = replies_due.pop_front();
               if (got.stored !== want.stored || got.fresh !== want.fresh ||
                   got.in_range !== want.in_range || got.angle !== want.angle ||
                   rsp_tdata[15] !== 1'b0) begin
                  fault_count++;
                  if (fault_count <= 10)
                     $display({"%0t: reply mismatch, expected/actual: stored %0b/%0b ",
                               "fresh %0b/%0b in_range %0b/%0b angle %0d/%0d pad 0/%0b"},
                              $realtime, want.stored, got.stored, want.fresh, got.fresh,
                              want.in_range, got.in_range, want.angle, got.angle,
                              rsp_tdata[15]);
               end
            end
         end
         if (req_tvalid && req_tready)
            replies_due.push_back(parse_beat(op_type'(req_tuser), req_tdata[7:0],
                                             req_tdata[15:8]));
      end
      pending    <= replies_due.size();
      mismatches <= fault_count;
   end

endmodule

/* dv/servo_angle_frame_parser_tb.sv */
module servo_angle_frame_parser_tb;
   import safp_pkg::*;

   localparam int BEAT_TARGET = 900;
   localparam int HOLD_CYCLES = 300;
   localparam int IDLE_LIMIT  = 4000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;

   int mismatches;
   int pending;
   int beats_sent  = 0;
   int idle_cycles = 0;
   bit drain_next  = 1'b0;

   servo_angle_frame_parser uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   servo_angle_frame_parser_checker #(
      .NUM_SERVOS (NUM_SERVOS_DEF)
   ) reply_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .mismatches (mismatches),
      .pending    (pending)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Mostly short gaps, a few long ones; none at all in calm stretches.
   function automatic int pick_gap(input bit calm);
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] pick_servo();
      if ($urandom_range(0, 4) != 0) return 8'($urandom_range(0, NUM_SERVOS_DEF - 1));
      return 8'($urandom);
   endfunction

   function automatic logic [7:0] digit_char(input int v);
      return CH_ZERO + 8'(v % 10);
   endfunction

   task automatic send_beat(input op_type op, input logic [7:0] ch, input logic [7:0] sid);
      int gap;
      gap = pick_gap((beats_sent / 64) % 4 == 1);
      if (drain_next) begin
         // hold the sender until every reply is back
         drain_next = 1'b0;
         req_tvalid <= 1'b0;
         @(posedge clock);
         while (pending != 0) @(posedge clock);
      end else if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {sid, ch};
      do @(posedge clock); while (!req_tready);
      beats_sent++;
   endtask

   task automatic send_byte(input logic [7:0] ch);
      send_beat(OP_BYTE, ch, 8'($urandom));
   endtask

   task automatic send_query(input logic [7:0] sid);
      send_beat(OP_QUERY, 8'($urandom), sid);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   // One reply frame with random content, now and then damaged, cut short or overlong.
   task automatic send_frame();
      logic [7:0] body [FRAME_CHARS];
      int id_val;
      int ang_val;
      int r;
      int n_chars;
      r = $urandom_range(0, 99);
      if (r < 70)      id_val = $urandom_range(0, NUM_SERVOS_DEF - 1);
      else if (r < 80) id_val = $urandom_range(NUM_SERVOS_DEF, 9);
      else if (r < 90) id_val = $urandom_range(254, 261);
      else             id_val = $urandom_range(0, 999);
      case ($urandom_range(0, 11))
         0:       ang_val = 0;
         1:       ang_val = 500;
         2:       ang_val = 501;
         3:       ang_val = 2499;
         4:       ang_val = 2500;
         5:       ang_val = 1000;
         6:       ang_val = 4095;
         7:       ang_val = 9999;
         default: ang_val = $urandom_range(0, 9999);
      endcase
      body[0] = digit_char(id_val / 100);
      body[1] = digit_char(id_val / 10);
      body[2] = digit_char(id_val);
      body[3] = ($urandom_range(0, 9) == 0) ? 8'($urandom) : CH_P;
      body[4] = digit_char(ang_val / 1000);
      body[5] = digit_char(ang_val / 100);
      body[6] = digit_char(ang_val / 10);
      body[7] = digit_char(ang_val);
      // non-digit characters make the decode wrap
      if ($urandom_range(0, 7) == 0) body[3'($urandom_range(0, 7))] = 8'($urandom);
      n_chars = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : 8;
      send_byte(CH_HASH);
      for (int i = 0; i < n_chars; i++) begin
         if ($urandom_range(0, 19) == 0) send_query(pick_servo());
         send_byte(body[i]);
      end
      if (n_chars == 8) begin
         if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
         if ($urandom_range(0, 9) != 0) send_byte(CH_BANG);
      end
   endtask

   initial begin
      bit drain_done;
      int r;
      drain_done = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 16'd0;
      req_tuser  = OP_BYTE;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_query(8'd0);
      send_query(8'hFF);
      send_text("#003P2499!");
      send_query(8'd3);
      send_text("#256P0500!");
      send_query(8'd0);

      while (beats_sent < BEAT_TARGET) begin
         if (!drain_done && beats_sent >= 600) begin
            drain_done = 1'b1;
            drain_next = 1'b1;
         end
         r = $urandom_range(0, 9);
         if (r < 6)      send_frame();
         else if (r < 8) repeat ($urandom_range(1, 3)) send_query(pick_servo());
         else            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("servo_angle_frame_parser_tb passed");
      end else begin
         $display("servo_angle_frame_parser_tb failed");
      end
      $finish;
   end

   initial begin
      int  stall_left;
      int  cyc;
      bit  hold_done;
      stall_left = 0;
      cyc        = 0;
      hold_done  = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         cyc++;
         if (reset) begin
            rsp_tready <= 1'b0;
         end else if (!hold_done && beats_sent >= 300) begin
            // long back-pressure: let the block fill up and stall its input
            hold_done  = 1'b1;
            stall_left = HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = pick_gap((cyc / 200) % 4 == 2);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("servo_angle_frame_parser_tb failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
